@@ rtl/core/dnsa_pkg.sv @@
// Shared types and constants for the DNS answer A-record extractor.
package dnsa_pkg;

	// Fixed header length of a DNS message in bytes.
	localparam int unsigned HDR_LEN = 12;
	// A name byte at or above this value starts a compression pointer.
	localparam logic [7:0] PTR_MARK = 8'd192;
	// Length of the fixed part of an answer record (type, class, TTL, length).
	localparam logic [15:0] AFIX_LEN = 16'd10;
	// Type and class bytes that follow the question name.
	localparam logic [15:0] QTAIL_LEN = 16'd4;
	// Record type and payload length of an IPv4 address record.
	localparam logic [15:0] TYPE_A = 16'd1;
	localparam logic [15:0] ADDR_LEN = 16'd4;

	// One message byte with its end-of-message flag.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	// One lookup result.
	typedef struct packed {
		logic        found;
		logic [31:0] ipv4_address;
	} out_t;

endpackage

@@ rtl/core/dnsa_parser.sv @@
// Byte-wise DNS response parser state and its next-state logic.
module dnsa_parser #(
	parameter int unsigned MAX_LEN = 512
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  dnsa_pkg::in_t  item,
	output dnsa_pkg::out_t result
);
	import dnsa_pkg::*;

	localparam int unsigned PW = $clog2(MAX_LEN + 1);

	typedef enum logic [3:0] {
		PH_HDR,
		PH_QLEN,
		PH_QSKIP,
		PH_QPTR,
		PH_QTAIL,
		PH_ALEN,
		PH_ASKIP,
		PH_APTR,
		PH_AFIX,
		PH_RDATA,
		PH_DONE
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [PW-1:0] pos_q, pos_n;
	logic [15:0] answers_q, answers_n;
	logic [15:0] skip_q, skip_n;
	logic [15:0] rtype_q, rtype_n;
	logic [15:0] plen_q, plen_n;
	logic [31:0] addr_q, addr_n;
	logic        found_q, found_n;

	logic [15:0] skip_inc;
	logic [15:0] ans_dec;
	phase_t      after_record;
	logic        in_question;

	// Helper values shared by several phases.
	always_comb begin
		skip_inc     = skip_q + 16'd1;
		ans_dec      = answers_q - 16'd1;
		after_record = (ans_dec == 16'd0) ? PH_DONE : PH_ALEN;
		in_question  = (phase_q == PH_QLEN) || (phase_q == PH_QSKIP);
	end

	// Next state for one message byte.
	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		answers_n = answers_q;
		skip_n    = skip_q;
		rtype_n   = rtype_q;
		plen_n    = plen_q;
		addr_n    = addr_q;
		found_n   = found_q;
		if (pos_q < PW'(MAX_LEN)) begin
			pos_n = pos_q + PW'(1);
			unique case (phase_q)
				PH_HDR: begin
					if (pos_q == PW'(6)) begin
						answers_n = {item.data_byte, 8'h00};
					end else if (pos_q == PW'(7)) begin
						answers_n = {answers_q[15:8], item.data_byte};
					end
					if (pos_q == PW'(HDR_LEN - 1)) begin
						phase_n = PH_QLEN;
					end
				end
				PH_QLEN, PH_ALEN: begin
					if (item.data_byte == 8'd0) begin
						skip_n  = 16'd0;
						phase_n = in_question ? PH_QTAIL : PH_AFIX;
					end else if (item.data_byte >= PTR_MARK) begin
						phase_n = in_question ? PH_QPTR : PH_APTR;
					end else begin
						skip_n  = {8'h00, item.data_byte};
						phase_n = in_question ? PH_QSKIP : PH_ASKIP;
					end
				end
				PH_QSKIP, PH_ASKIP: begin
					skip_n = skip_q - 16'd1;
					if (skip_n == 16'd0) begin
						phase_n = in_question ? PH_QLEN : PH_ALEN;
					end
				end
				PH_QPTR: begin
					skip_n  = 16'd0;
					phase_n = PH_QTAIL;
				end
				PH_APTR: begin
					skip_n  = 16'd0;
					phase_n = PH_AFIX;
				end
				PH_QTAIL: begin
					skip_n = skip_inc;
					if (skip_inc >= QTAIL_LEN) begin
						phase_n = (answers_q == 16'd0) ? PH_DONE : PH_ALEN;
					end
				end
				PH_AFIX: begin
					if (skip_q == 16'd0) begin
						rtype_n = {item.data_byte, 8'h00};
					end else if (skip_q == 16'd1) begin
						rtype_n = {rtype_q[15:8], item.data_byte};
					end else if (skip_q == 16'd8) begin
						plen_n = {item.data_byte, 8'h00};
					end else if (skip_q == 16'd9) begin
						plen_n = {plen_q[15:8], item.data_byte};
					end
					skip_n = skip_inc;
					if (skip_inc >= AFIX_LEN) begin
						skip_n = 16'd0;
						if (plen_n == 16'd0) begin
							answers_n = ans_dec;
							phase_n   = after_record;
						end else begin
							phase_n = PH_RDATA;
						end
					end
				end
				PH_RDATA: begin
					skip_n = skip_inc;
					if (rtype_q == TYPE_A && plen_q == ADDR_LEN) begin
						addr_n = {addr_q[23:0], item.data_byte};
						if (skip_inc >= ADDR_LEN) begin
							found_n = 1'b1;
							phase_n = PH_DONE;
						end
					end else if (skip_inc >= plen_q) begin
						answers_n = ans_dec;
						phase_n   = after_record;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result as it stands after this byte.
	always_comb begin
		result.found        = found_n;
		result.ipv4_address = found_n ? addr_n : 32'd0;
	end

	// State registers; the last byte of a message returns them to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR;
			pos_q     <= '0;
			answers_q <= '0;
			skip_q    <= '0;
			rtype_q   <= '0;
			plen_q    <= '0;
			addr_q    <= '0;
			found_q   <= 1'b0;
		end else if (step) begin
			if (item.last_byte) begin
				phase_q   <= PH_HDR;
				pos_q     <= '0;
				answers_q <= '0;
				skip_q    <= '0;
				rtype_q   <= '0;
				plen_q    <= '0;
				addr_q    <= '0;
				found_q   <= 1'b0;
			end else begin
				phase_q   <= phase_n;
				pos_q     <= pos_n;
				answers_q <= answers_n;
				skip_q    <= skip_n;
				rtype_q   <= rtype_n;
				plen_q    <= plen_n;
				addr_q    <= addr_n;
				found_q   <= found_n;
			end
		end
	end

endmodule

@@ rtl/core/dnsa_result_reg.sv @@
// Output register that holds one result until the consumer takes it.
module dnsa_result_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  dnsa_pkg::out_t load_data,
	input  logic           res_ready,
	output logic           res_valid,
	output dnsa_pkg::out_t res_data
);
	import dnsa_pkg::*;

	logic valid_q;
	out_t data_q;

	// Valid flag: set on load, cleared when the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload is captured only on load.
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

	assign res_valid = valid_q;
	assign res_data  = data_q;

endmodule

@@ rtl/core/dns_answer_a_record_extractor_core.sv @@
// Top level of the DNS answer A-record extractor: input register, parser, result register.
//
// Takes a DNS response one byte per transaction on the msg channel and, on the byte
// flagged as last, delivers one result on the res channel: found and the IPv4 address of
// the first complete type 1 answer with a 4-byte payload. One byte is accepted every
// cycle; a byte is held in the input register, and the parser state advances
// at the clock edge that takes it out, so a result is offered from the clock edge that
// follows the acceptance of its last byte. Only a last byte waits, and
// only while the previous result is still unclaimed on the res channel. Bytes beyond
// MAX_LEN-1 are not parsed.
module dns_answer_a_record_extractor_core #(
	parameter int unsigned MAX_LEN = 512
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           msg_valid,
	output logic           msg_ready,
	input  dnsa_pkg::in_t  msg_data,
	output logic           res_valid,
	input  logic           res_ready,
	output dnsa_pkg::out_t res_data
);
	import dnsa_pkg::*;

	logic valid_s1;
	in_t  data_s1;
	logic fire_s1;
	logic emit;
	out_t step_result;

	// A byte leaves the input register unless it would overwrite a waiting result.
	always_comb begin
		fire_s1   = valid_s1 && (!data_s1.last_byte || !res_valid || res_ready);
		msg_ready = !valid_s1 || fire_s1;
		emit      = fire_s1 && data_s1.last_byte;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg_valid && msg_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_valid && msg_ready) begin
			data_s1 <= msg_data;
		end
	end

	// Parser state machine.
	dnsa_parser #(
		.MAX_LEN(MAX_LEN)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (fire_s1),
		.item  (data_s1),
		.result(step_result)
	);

	// Result register.
	dnsa_result_reg u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (emit),
		.load_data(step_result),
		.res_ready(res_ready),
		.res_valid(res_valid),
		.res_data (res_data)
	);

endmodule

@@ rtl/core/dnsa_checker.sv @@
// Port-level checks for the DNS answer A-record extractor, bound to the top level.
module dnsa_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           msg_valid,
	input logic           msg_ready,
	input dnsa_pkg::in_t  msg_data,
	input logic           res_valid,
	input logic           res_ready,
	input dnsa_pkg::out_t res_data
);
	import dnsa_pkg::*;

	// A pending result stays offered until its transaction completes.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result dropped or changed while stalled");

	// A not-found result carries a zero address.
	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.found |-> res_data.ipv4_address == 32'd0)
		else $error("not-found result with nonzero address");

	// A new result follows a last byte that was accepted and passed through the input register.
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(msg_valid && msg_ready && msg_data.last_byte, 2))
		else $error("result without a preceding last byte");

	// The input side is held back only while a result waits to be taken.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!msg_ready |-> res_valid)
		else $error("input stalled with no pending result");

endmodule

bind dns_answer_a_record_extractor_core dnsa_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.msg_valid(msg_valid),
	.msg_ready(msg_ready),
	.msg_data (msg_data),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res_data (res_data)
);
